// File: hdl/ceb_pkg.sv
// Shared constants and width helpers for the cubic Bezier easing block.
`default_nettype none

package ceb_pkg;

  localparam int FracBitsDef   = 15;
  localparam int FieldW        = 16;
  localparam int IterW         = 6;
  localparam int IterCap       = 32;
  localparam int MaxIterReset  = 12;

  // Signed width of the curve parameter t. It must hold any 16-bit start value
  // and the clamp bound of four.
  function automatic int t_width(input int frac_bits);
    int w;
    begin
      w = (frac_bits + 4 > FieldW + 1) ? frac_bits + 4 : FieldW + 1;
      return w;
    end
  endfunction

  // Signed width of the Horner accumulator. Each multiply by t can grow the
  // magnitude by the integer bits of t, plus one bit for the added coefficient.
  function automatic int acc_width(input int frac_bits);
    int kw;
    int grow;
    begin
      kw   = ((frac_bits > 19) ? frac_bits : 19) + 2;
      grow = t_width(frac_bits) - 1 - frac_bits;
      return kw + 3 * (grow + 1);
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/ceb_horner_cell.sv
// One Horner step: acc_o = round(acc_i * t_i / 2^FRAC_BITS) + addend_i, registered.
`default_nettype none

module ceb_horner_cell #(
  parameter int FRAC_BITS = 15,
  parameter int AccW      = 30,
  parameter int TW        = 18
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire logic signed [TW-1:0]   t_i,
  input  wire logic signed [AccW-1:0] acc_i,
  input  wire logic signed [AccW-1:0] addend_i,
  output logic                        valid_o,
  output logic signed [TW-1:0]        t_o,
  output logic signed [AccW-1:0]      acc_o
);
  import ceb_pkg::*;

  localparam int PW = AccW + TW;
  localparam logic [PW:0] HalfQ = {{(PW - FRAC_BITS + 1){1'b0}}, 1'b1,
                                   {(FRAC_BITS - 1){1'b0}}};

  logic signed [PW-1:0]   prod;
  logic signed [PW:0]     rnd;
  logic signed [PW:0]     shf;
  logic signed [AccW-1:0] acc_d;
  logic                   valid_q;
  logic signed [TW-1:0]   t_q;
  logic signed [AccW-1:0] acc_q;

  always_comb begin
    prod  = acc_i * t_i;
    // Round to nearest with ties upward, then floor through the arithmetic shift.
    rnd   = $signed({prod[PW-1], prod}) + $signed(HalfQ);
    shf   = rnd >>> FRAC_BITS;
    acc_d = $signed(shf[AccW-1:0]) + addend_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      t_q   <= t_i;
      acc_q <= acc_d;
    end
  end

  assign valid_o = valid_q;
  assign t_o     = t_q;
  assign acc_o   = acc_q;

endmodule

`default_nettype wire

// File: hdl/cubic_bezier_easing.sv
// Cubic Bezier easing: solves Bx(t) = x by halved-residual steps, then gives By(t).
// Both control points on the diagonal skip the solver; otherwise at most
// min(max_iterations, 32) solver steps are taken before By(t) is evaluated.
// Each curve evaluation passes through the three-cell Horner chain plus a launch
// register; one item is in work at a time, the next is taken once it ends.
// Reset (asynchronous, active low) empties the chain and output, max_iterations = 12.
`default_nettype none

module cubic_bezier_easing #(
  parameter int FRAC_BITS = ceb_pkg::FracBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [ceb_pkg::FieldW-1:0]  progress_i,
  input  wire logic [ceb_pkg::FieldW-1:0]  ctrl1_x_i,
  input  wire logic [ceb_pkg::FieldW-1:0]  ctrl1_y_i,
  input  wire logic [ceb_pkg::FieldW-1:0]  ctrl2_x_i,
  input  wire logic [ceb_pkg::FieldW-1:0]  ctrl2_y_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [ceb_pkg::FieldW-1:0]       eased_value_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ceb_pkg::IterW-1:0]   max_iterations_i
);
  import ceb_pkg::*;

  localparam int TW   = t_width(FRAC_BITS);
  localparam int AccW = acc_width(FRAC_BITS);
  localparam int FW   = AccW + 2;
  localparam int OneInt = 1 << FRAC_BITS;
  localparam int TolInt = (OneInt + 1000) / 2000;
  localparam int YLimInt = (OneInt > 65535) ? 65535 : OneInt;

  localparam logic signed [AccW-1:0] OneQ  = AccW'(OneInt);
  localparam logic signed [AccW-1:0] YLim  = AccW'(YLimInt);
  localparam logic signed [FW-1:0]   TolQ  = FW'(TolInt);
  localparam logic signed [FW-1:0]   TLim  = FW'(4 * OneInt);
  localparam logic [IterW-1:0]       IterCapV = IterW'(IterCap);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StEvalX = 2'd1;
  localparam logic [1:0] StEvalY = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [IterW-1:0]       max_iter_q;
  logic [IterW-1:0]       iter_q, iter_d;
  logic [IterW-1:0]       n_q, n_d;
  logic                   launch_q, launch_d;
  logic signed [TW-1:0]   t_q, t_d;
  logic signed [AccW-1:0] x_q;
  logic signed [AccW-1:0] k3x_q, k2x_q, k1x_q, k3y_q, k2y_q, k1y_q;
  logic [FieldW-1:0]      hold_q, hold_d;
  logic                   out_valid_q;
  logic [FieldW-1:0]      out_data_q;

  logic signed [AccW-1:0] ax_s, ay_s, bx_s, by_s;
  logic                   accept;
  logic                   out_free;
  logic                   diag;

  logic signed [AccW-1:0] sel_k3, sel_k2, sel_k1;
  logic                   c0_valid, c1_valid, c2_valid;
  logic signed [TW-1:0]   c0_t, c1_t, c2_t;
  logic signed [AccW-1:0] c0_acc, c1_acc, c2_acc;

  logic signed [FW-1:0]   f_res;
  logic signed [FW-1:0]   f_half;
  logic signed [FW-1:0]   t_step;
  logic signed [TW-1:0]   t_clamped;
  logic                   within_tol;
  logic                   last_step;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != StIdle);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign diag        = (ctrl1_x_i == ctrl1_y_i) && (ctrl2_x_i == ctrl2_y_i);

  always_comb begin
    ax_s = $signed(AccW'(ctrl1_x_i));
    ay_s = $signed(AccW'(ctrl1_y_i));
    bx_s = $signed(AccW'(ctrl2_x_i));
    by_s = $signed(AccW'(ctrl2_y_i));
  end

  // The chain evaluates the y polynomial only in StEvalY.
  always_comb begin
    if (state_q == StEvalY) begin
      sel_k3 = k3y_q;
      sel_k2 = k2y_q;
      sel_k1 = k1y_q;
    end else begin
      sel_k3 = k3x_q;
      sel_k2 = k2x_q;
      sel_k1 = k1x_q;
    end
  end

  ceb_horner_cell #(.FRAC_BITS(FRAC_BITS), .AccW(AccW), .TW(TW)) u_cell0 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (launch_q),
    .t_i      (t_q),
    .acc_i    (sel_k3),
    .addend_i (sel_k2),
    .valid_o  (c0_valid),
    .t_o      (c0_t),
    .acc_o    (c0_acc)
  );

  ceb_horner_cell #(.FRAC_BITS(FRAC_BITS), .AccW(AccW), .TW(TW)) u_cell1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (c0_valid),
    .t_i      (c0_t),
    .acc_i    (c0_acc),
    .addend_i (sel_k1),
    .valid_o  (c1_valid),
    .t_o      (c1_t),
    .acc_o    (c1_acc)
  );

  ceb_horner_cell #(.FRAC_BITS(FRAC_BITS), .AccW(AccW), .TW(TW)) u_cell2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (c1_valid),
    .t_i      (c1_t),
    .acc_i    (c1_acc),
    .addend_i ('0),
    .valid_o  (c2_valid),
    .t_o      (c2_t),
    .acc_o    (c2_acc)
  );

  // Residual and the halved step; the halving truncates toward zero.
  always_comb begin
    f_res      = FW'(c2_acc) - FW'(x_q);
    f_half     = (f_res + (f_res[FW-1] ? FW'(1) : FW'(0))) >>> 1;
    t_step     = FW'(c2_t) - f_half;
    within_tol = (f_res <= TolQ) && (f_res >= -TolQ);
    last_step  = (IterW'(iter_q + 1'b1) == n_q);
    if (t_step > TLim) begin
      t_clamped = TW'(TLim);
    end else if (t_step < -TLim) begin
      t_clamped = TW'(-TLim);
    end else begin
      t_clamped = t_step[TW-1:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    iter_d   = iter_q;
    n_d      = n_q;
    launch_d = 1'b0;
    t_d      = t_q;
    hold_d   = hold_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          t_d    = $signed(TW'(progress_i));
          iter_d = '0;
          n_d    = (max_iter_q > IterCapV) ? IterCapV : max_iter_q;
          hold_d = progress_i;
          if (diag) begin
            state_d = StDone;
          end else if (n_d == '0) begin
            state_d  = StEvalY;
            launch_d = 1'b1;
          end else begin
            state_d  = StEvalX;
            launch_d = 1'b1;
          end
        end
      end
      StEvalX: begin
        if (c2_valid) begin
          launch_d = 1'b1;
          if (within_tol) begin
            state_d = StEvalY;
          end else begin
            t_d    = t_clamped;
            iter_d = IterW'(iter_q + 1'b1);
            if (last_step) begin
              state_d = StEvalY;
            end
          end
        end
      end
      StEvalY: begin
        if (c2_valid) begin
          state_d = StDone;
          if (c2_acc < 0) begin
            hold_d = '0;
          end else if (c2_acc > YLim) begin
            hold_d = FieldW'(YLim);
          end else begin
            hold_d = c2_acc[FieldW-1:0];
          end
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      launch_q    <= 1'b0;
      iter_q      <= '0;
      n_q         <= '0;
      max_iter_q  <= IterW'(MaxIterReset);
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      iter_q   <= iter_d;
      n_q      <= n_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_iter_q <= max_iterations_i;
      end
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    hold_q <= hold_d;
    if (accept) begin
      x_q   <= $signed(AccW'(progress_i));
      k3x_q <= OneQ + 3 * ax_s - 3 * bx_s;
      k2x_q <= 3 * bx_s - 6 * ax_s;
      k1x_q <= 3 * ax_s;
      k3y_q <= OneQ + 3 * ay_s - 3 * by_s;
      k2y_q <= 3 * by_s - 6 * ay_s;
      k1y_q <= 3 * ay_s;
    end
    if (state_q == StDone && out_free) begin
      out_data_q <= hold_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign eased_value_o = out_data_q;

  // Only one evaluation is ever in flight through the launch register and chain.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({launch_q, c0_valid, c1_valid, c2_valid}))
    else $error("more than one evaluation in the Horner chain");

  // Chain results arrive only while the controller waits for them.
  a_result_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c2_valid |-> (state_q == StEvalX || state_q == StEvalY))
    else $error("chain result in a state that ignores it");

  // The solver never runs past its step limit.
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEvalX) |-> (iter_q < n_q))
    else $error("solver step count beyond limit");

  // A finished item always reaches the output register.
  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && out_free) |=> (out_valid_q && state_q == StIdle))
    else $error("finished result not delivered");

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the cubic Bezier easing block, with a predicting scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ceb_pkg::*;

  localparam int     FracBits  = FracBitsDef;
  localparam longint OneQ      = longint'(1) << FracBits;
  localparam longint HalfQ     = longint'(1) << (FracBits - 1);
  localparam longint TolLsb    = (OneQ + 1000) / 2000;
  localparam longint TLimit    = 4 * OneQ;
  localparam longint FieldMax  = (longint'(1) << FieldW) - 1;
  localparam longint YLimit    = (OneQ > FieldMax) ? FieldMax : OneQ;
  localparam int     DrainWait = 150;
  localparam int     LongHold  = 400;
  localparam int     PhaseLen  = 142;

  typedef logic [FieldW-1:0] q_t;

  typedef struct packed {
    q_t progress;
    q_t ctrl1_x;
    q_t ctrl1_y;
    q_t ctrl2_x;
    q_t ctrl2_y;
  } easing_req_t;

  class easing_scoreboard;
    int unsigned      errors;
    logic [IterW-1:0] iter_limit;
    q_t               pending_eased[$];

    function new();
      errors     = 0;
      iter_limit = IterW'(MaxIterReset);
    endfunction

    function void set_iter_limit(logic [IterW-1:0] v);
      iter_limit = v;
    endfunction

    // Product rescaled by 2^FracBits, rounding to nearest with ties upward.
    function longint mul_fix(longint a, longint b);
      return (a * b + HalfQ) >>> FracBits;
    endfunction

    function longint horner3(longint c3, longint c2, longint c1, longint t);
      longint acc;
      acc = mul_fix(c3, t) + c2;
      acc = mul_fix(acc, t) + c1;
      return mul_fix(acc, t);
    endfunction

    function q_t predict_eased(easing_req_t r);
      longint x  = longint'(r.progress);
      longint ax = longint'(r.ctrl1_x);
      longint ay = longint'(r.ctrl1_y);
      longint bx = longint'(r.ctrl2_x);
      longint by = longint'(r.ctrl2_y);
      longint t, f, y;
      int     steps;
      steps = (iter_limit > IterCap) ? IterCap : int'(iter_limit);
      if (ax == ay && bx == by) return r.progress;
      t = x;
      for (int i = 0; i < steps; i++) begin
        f = horner3(OneQ + 3 * ax - 3 * bx, 3 * bx - 6 * ax, 3 * ax, t) - x;
        if (f <= TolLsb && f >= -TolLsb) break;
        // Signed division truncates toward zero here.
        t = t - f / 2;
        if (t > TLimit) t = TLimit;
        if (t < -TLimit) t = -TLimit;
      end
      y = horner3(OneQ + 3 * ay - 3 * by, 3 * by - 6 * ay, 3 * ay, t);
      if (y < 0) y = 0;
      if (y > YLimit) y = YLimit;
      return q_t'(y);
    endfunction

    function void note_request(easing_req_t r);
      pending_eased.push_back(predict_eased(r));
    endfunction

    function void check_eased(q_t got);
      q_t want;
      if (pending_eased.size() == 0) begin
        $error("eased_value: no transaction expected, actual %0d", got);
        errors++;
        return;
      end
      want = pending_eased.pop_front();
      if (got !== want) begin
        $error("eased_value mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_eased.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  q_t               progress_i;
  q_t               ctrl1_x_i;
  q_t               ctrl1_y_i;
  q_t               ctrl2_x_i;
  q_t               ctrl2_y_i;
  logic             out_valid_o;
  logic             out_stall_i;
  q_t               eased_value_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [IterW-1:0] max_iterations_i;

  easing_scoreboard sb;
  int               send_idle_pct;
  int               stall_pct;
  logic             long_hold_go;

  cubic_bezier_easing dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .progress_i       (progress_i),
    .ctrl1_x_i        (ctrl1_x_i),
    .ctrl1_y_i        (ctrl1_y_i),
    .ctrl2_x_i        (ctrl2_x_i),
    .ctrl2_y_i        (ctrl2_y_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .eased_value_o    (eased_value_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .max_iterations_i (max_iterations_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("tb: done, errors");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin : receiver
    logic long_hold_done;
    long_hold_done = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_eased(eased_value_o);
  end

  task automatic send_req(easing_req_t r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    progress_i <= r.progress;
    ctrl1_x_i  <= r.ctrl1_x;
    ctrl1_y_i  <= r.ctrl1_y;
    ctrl2_x_i  <= r.ctrl2_x;
    ctrl2_y_i  <= r.ctrl2_y;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
  endtask

  // Waits until every transaction has come back and the block has settled.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_iter_limit(logic [IterW-1:0] v);
    drain();
    cfg_valid_i      <= 1'b1;
    max_iterations_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_iter_limit(v);
  endtask

  function automatic easing_req_t random_req();
    easing_req_t r;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // Control points on the diagonal; progress may be any 16-bit value.
      r.progress = q_t'($urandom);
      r.ctrl1_x  = q_t'($urandom_range(0, 32768));
      r.ctrl2_x  = q_t'($urandom_range(0, 32768));
      r.ctrl1_y  = r.ctrl1_x;
      r.ctrl2_y  = r.ctrl2_x;
    end else if (pick < 80) begin
      r.progress = q_t'($urandom_range(0, 32768));
      r.ctrl1_x  = q_t'($urandom_range(0, 32768));
      r.ctrl1_y  = q_t'($urandom_range(0, 32768));
      r.ctrl2_x  = q_t'($urandom_range(0, 32768));
      r.ctrl2_y  = q_t'($urandom_range(0, 32768));
    end else if (pick < 90) begin
      // Overshooting curves, with y control values that may lie past one.
      r.progress = q_t'($urandom_range(0, 32768));
      r.ctrl1_x  = q_t'($urandom_range(0, 32768));
      r.ctrl1_y  = q_t'($urandom);
      r.ctrl2_x  = q_t'($urandom_range(0, 32768));
      r.ctrl2_y  = q_t'($urandom);
    end else begin
      r.progress = q_t'($urandom);
      r.ctrl1_x  = q_t'($urandom);
      r.ctrl1_y  = q_t'($urandom);
      r.ctrl2_x  = q_t'($urandom);
      r.ctrl2_y  = q_t'($urandom);
    end
    return r;
  endfunction

  initial begin : stimulus
    easing_req_t      directed[$];
    logic [IterW-1:0] iter_settings[6];
    sb = new();
    send_idle_pct = 30;
    stall_pct     = 73;
    long_hold_go  = 1'b0;
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    progress_i       <= '0;
    ctrl1_x_i        <= '0;
    ctrl1_y_i        <= '0;
    ctrl2_x_i        <= '0;
    ctrl2_y_i        <= '0;
    cfg_valid_i      <= 1'b0;
    max_iterations_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Diagonal pass-through, including progress values past one.
    directed.push_back('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    directed.push_back('{16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768});
    directed.push_back('{16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0});
    directed.push_back('{16'd12345, 16'hFFFF, 16'hFFFF, 16'd100, 16'd100});
    // Common ease curve at start, middle and end.
    directed.push_back('{16'd0, 16'd8192, 16'd3277, 16'd8192, 16'd32768});
    directed.push_back('{16'd16384, 16'd8192, 16'd3277, 16'd8192, 16'd32768});
    directed.push_back('{16'd32768, 16'd8192, 16'd3277, 16'd8192, 16'd32768});
    // Only one control point on the diagonal.
    directed.push_back('{16'd20000, 16'd8192, 16'd8192, 16'd24576, 16'd4096});
    directed.push_back('{16'd9000, 16'd30000, 16'd1000, 16'd16384, 16'd16384});
    // Steep curves that push t out toward the clamp.
    directed.push_back('{16'd16384, 16'd32768, 16'd0, 16'd0, 16'd32768});
    directed.push_back('{16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF});
    directed.push_back('{16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0});
    directed.push_back('{16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0});
    // Results above one and below zero saturate.
    directed.push_back('{16'd16384, 16'd8192, 16'hFFFF, 16'd24576, 16'hFFFF});
    directed.push_back('{16'd4096, 16'd8192, 16'd0, 16'd24576, 16'hFFFF});
    directed.push_back('{16'd30000, 16'd0, 16'hFFFF, 16'd32768, 16'd0});
    directed.push_back('{16'd1, 16'd1, 16'd2, 16'd32767, 16'd32766});
    directed.push_back('{16'd32767, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000});
    foreach (directed[i]) send_req(directed[i]);

    iter_settings = '{6'd0, 6'd63, 6'd32, 6'd1, 6'd12, IterW'($urandom_range(2, 31))};
    for (int p = 0; p < 6; p++) begin
      write_iter_limit(iter_settings[p]);
      send_idle_pct = (p < 2) ? 30 : (p < 4) ? 73 : 0;
      stall_pct     = (p < 2) ? 73 : (p < 4) ? 30 : 0;
      if (p == 1) long_hold_go = 1'b1;
      for (int n = 0; n < PhaseLen; n++) send_req(random_req());
    end

    drain();
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
